### hdl/lkce_pkg.sv
// ----------------------------------------------------------------------------
// lkce_pkg
// Shared types and constants for the ladder keypad code entry block: key
// codes, result status codes, entry phases and the voltage window table.
// ----------------------------------------------------------------------------
package lkce_pkg;

  localparam int SAMPLE_W = 8;
  localparam int KEY_W    = 4;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 2;
  localparam int BOUND_W  = 9;
  localparam int NUM_WIN  = 14;

  // Key codes beyond the digits 0 to 9
  localparam logic [KEY_W-1:0] KEY_TEN    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_CANCEL = 4'd11;
  localparam logic [KEY_W-1:0] KEY_UNUSED = 4'd12;
  localparam logic [KEY_W-1:0] KEY_IDLE   = 4'd13;
  localparam logic [KEY_W-1:0] KEY_ERROR  = 4'd14;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_WAIT    = 3'd0,
    ST_DIGIT   = 3'd1,
    ST_DONE    = 3'd2,
    ST_NOKEY   = 3'd3,
    ST_INVALID = 3'd4,
    ST_CANCEL  = 3'd5
  } status_t;

  // Code entry phases
  typedef enum logic [1:0] {
    PH_NONE    = 2'd0,
    PH_RELEASE = 2'd1,
    PH_PRESS   = 2'd2
  } phase_t;

  // One voltage window: both bounds exclusive
  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic [KEY_W-1:0]   code;
  } window_t;

  // Windows in priority order; the first match wins
  localparam window_t WINDOWS [NUM_WIN] = '{
    '{lo: 9'd17,  hi: 9'd23,  code: 4'd1},
    '{lo: 9'd35,  hi: 9'd41,  code: 4'd2},
    '{lo: 9'd50,  hi: 9'd56,  code: 4'd3},
    '{lo: 9'd103, hi: 9'd109, code: 4'd4},
    '{lo: 9'd86,  hi: 9'd92,  code: 4'd5},
    '{lo: 9'd68,  hi: 9'd74,  code: 4'd6},
    '{lo: 9'd123, hi: 9'd129, code: 4'd7},
    '{lo: 9'd145, hi: 9'd151, code: 4'd8},
    '{lo: 9'd166, hi: 9'd172, code: 4'd9},
    '{lo: 9'd230, hi: 9'd236, code: 4'd0},
    '{lo: 9'd207, hi: 9'd213, code: KEY_TEN},
    '{lo: 9'd186, hi: 9'd192, code: KEY_CANCEL},
    '{lo: 9'd248, hi: 9'd252, code: KEY_UNUSED},
    '{lo: 9'd251, hi: 9'd256, code: KEY_IDLE}
  };

endpackage

### hdl/lkce_if.sv
// ----------------------------------------------------------------------------
// lkce_if
// Valid/ready channels of the ladder keypad code entry block: one for
// samples, one for results.
// ----------------------------------------------------------------------------
interface lkce_in_if import lkce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface lkce_out_if import lkce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key;
  logic [INDEX_W-1:0]  digit_index;

  modport source (output valid, output status, output key, output digit_index,
                  input ready);
  modport sink   (input valid, input status, input key, input digit_index,
                  output ready);
endinterface

### hdl/lkce_classify.sv
// ----------------------------------------------------------------------------
// lkce_classify
// Sorts one ladder sample into a key code through the window table.
// ----------------------------------------------------------------------------
module lkce_classify import lkce_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample,
  output logic [KEY_W-1:0]    key
);

  logic [BOUND_W-1:0] s_ext;

  assign s_ext = BOUND_W'(sample);

  // Walk the table backwards so the earliest matching window wins
  always_comb begin
    key = KEY_ERROR;
    for (int i = NUM_WIN - 1; i >= 0; i--) begin
      if (s_ext > WINDOWS[i].lo && s_ext < WINDOWS[i].hi) begin
        key = WINDOWS[i].code;
      end
    end
  end

endmodule

### hdl/ladder_keypad_code_entry.sv
// ----------------------------------------------------------------------------
// ladder_keypad_code_entry
// Decodes ladder keypad samples into keys and runs the code entry sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one settled 8-bit ladder sample per transfer, with start_req set on
//         the sample that opens a new entry (it is the first key read).
//   out : exactly one result per sample: status, the sample's key code and
//         the index of the digit accepted on that sample.
//   The sample is held in an input register, then classified and applied to
//   the entry state on its way into the result register. One sample is taken
//   every cycle while results are drained; the window compares and the phase
//   update are the only logic between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; in.ready drops only while both are occupied.
//   Reset empties both registers and leaves no entry running with no digits
//   taken.
// ----------------------------------------------------------------------------
module ladder_keypad_code_entry import lkce_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  lkce_in_if.sink     in,
  lkce_out_if.source  out
);

  localparam int CNT_W = $clog2(DIGITS + 1);

  // Input register
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_start;
  logic                advance;

  // Entry state
  phase_t              phase;
  phase_t              phase_next;
  logic [CNT_W-1:0]    digits_taken;
  logic [CNT_W-1:0]    digits_taken_next;
  logic [CNT_W-1:0]    cnt_inc;
  logic                full;

  // Decoded sample
  logic [KEY_W-1:0]    key;
  logic                is_nokey;
  logic                take_digit;

  // Result register
  logic                out_valid;
  status_t             status_reg;
  status_t             status_next;
  logic [KEY_W-1:0]    key_reg;
  logic [INDEX_W-1:0]  index_reg;
  logic [INDEX_W-1:0]  index_next;

  lkce_classify u_classify (
    .sample (s1_sample),
    .key    (key)
  );

  assign advance  = s1_valid && (!out_valid || out.ready);
  assign in.ready = !s1_valid || advance;

  assign is_nokey = (key == KEY_IDLE) || (key == KEY_ERROR);
  assign cnt_inc  = s1_start ? CNT_W'(1) : digits_taken + 1'b1;
  assign full     = cnt_inc >= CNT_W'(DIGITS);

  // Decide whether this sample is taken as the next digit
  always_comb begin
    if (s1_start) begin
      take_digit = !is_nokey && (key != KEY_TEN);
    end else if (phase == PH_PRESS) begin
      take_digit = !is_nokey && (key != KEY_CANCEL) && (key != KEY_UNUSED) &&
                   (key != KEY_TEN);
    end else begin
      take_digit = 1'b0;
    end
  end

  // Next phase and digit count
  always_comb begin
    phase_next        = phase;
    digits_taken_next = digits_taken;
    if (s1_start) begin
      digits_taken_next = take_digit ? cnt_inc : '0;
      phase_next        = (take_digit && !full) ? PH_RELEASE : PH_NONE;
    end else begin
      unique case (phase)
        PH_RELEASE: begin
          if (key == KEY_IDLE) begin
            phase_next = PH_PRESS;
          end
        end
        PH_PRESS: begin
          if (take_digit) begin
            digits_taken_next = cnt_inc;
            phase_next        = full ? PH_NONE : PH_RELEASE;
          end else if (!is_nokey) begin
            phase_next = PH_NONE;
          end
        end
        default: begin
          phase_next = PH_NONE;
        end
      endcase
    end
  end

  // Result fields
  always_comb begin
    status_next = ST_WAIT;
    index_next  = '0;
    if (take_digit) begin
      status_next = full ? ST_DONE : ST_DIGIT;
      index_next  = s1_start ? '0 : INDEX_W'(digits_taken);
    end else if (s1_start) begin
      status_next = is_nokey ? ST_NOKEY : ST_INVALID;
    end else if (phase == PH_PRESS && !is_nokey) begin
      status_next = (key == KEY_CANCEL) ? ST_CANCEL : ST_INVALID;
    end
  end

  // Load the input register on each transfer, drop it when it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.valid && in.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      s1_sample <= in.sample;
      s1_start  <= in.start_req;
    end
  end

  // Update entry state as each sample passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NONE;
      digits_taken <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      digits_taken <= digits_taken_next;
    end
  end

  // Result register: hold while stalled, clear after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_reg <= status_next;
      key_reg    <= key;
      index_reg  <= index_next;
    end
  end

  assign out.valid       = out_valid;
  assign out.status      = status_reg;
  assign out.key         = key_reg;
  assign out.digit_index = index_reg;

  // The digit count never passes the code length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digits_taken <= CNT_W'(DIGITS))
    else $error("digit count beyond code length");

  // Waiting for a press means an entry is under way and not yet full
  a_press_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PRESS |-> digits_taken != '0 && digits_taken < CNT_W'(DIGITS))
    else $error("press phase with bad digit count");

  // An accepted digit is never an idle or error reading
  a_digit_key: assert property (@(posedge clk) disable iff (rst)
    out.valid && (out.status == ST_DIGIT || out.status == ST_DONE) |->
      out.key != KEY_IDLE && out.key != KEY_ERROR)
    else $error("digit accepted from idle or error sample");

  // Input backpressure only when both registers are full and stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> s1_valid && out.valid && !out.ready)
    else $error("input stalled without a stalled result");

endmodule

### sim/ladder_keypad_code_entry_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladder_keypad_code_entry_tb
// Drives ladder samples into the keypad code entry block over its valid/ready
// channel and checks every result against an in-bench model of the window
// classifier and entry sequence. A short table of directed samples comes
// first, then mostly well-formed random entries with bounce and noise mixed
// in, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module ladder_keypad_code_entry_tb import lkce_pkg::*; ();

  localparam int ENTRY_DIGITS = 4;
  localparam int DIR_ROWS     = 25;
  localparam int RAND_ITEMS   = 475;   // per idling pattern

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [INDEX_W-1:0] idx;
  } entry_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start;
    logic                typed;   // expected result given in the row
    status_t             status;
    logic [KEY_W-1:0]    key;
    logic [INDEX_W-1:0]  idx;
  } dir_row_t;

  logic clk;
  logic rst;

  lkce_in_if  smp_ch ();
  lkce_out_if res_ch ();

  ladder_keypad_code_entry #(
    .DIGITS(ENTRY_DIGITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in (smp_ch),
    .out(res_ch)
  );

  // Entry state mirrored by the bench
  phase_t pred_phase = PH_NONE;
  int     pred_taken = 0;

  entry_result_t pending_results [$];
  int            mismatches     = 0;
  int            src_idle_pct   = 0;
  int            sink_stall_pct = 0;

  // Directed samples: edge keys, every key class, every status path
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{8'd0,   1'b1, 1'b1, ST_NOKEY,   KEY_ERROR,  2'd0},
    '{8'd255, 1'b1, 1'b1, ST_NOKEY,   KEY_IDLE,   2'd0},
    '{8'd210, 1'b1, 1'b1, ST_INVALID, KEY_TEN,    2'd0},
    '{8'd20,  1'b0, 1'b1, ST_WAIT,    4'd1,       2'd0},
    '{8'd20,  1'b1, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd233, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd0,   1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd253, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd0,   1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd38,  1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd252, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd148, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd255, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd169, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd89,  1'b0, 1'b1, ST_WAIT,    4'd5,       2'd0},
    '{8'd189, 1'b1, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd254, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd189, 1'b0, 1'b1, ST_CANCEL,  KEY_CANCEL, 2'd0},
    '{8'd250, 1'b1, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd255, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd251, 1'b0, 1'b1, ST_INVALID, KEY_UNUSED, 2'd0},
    '{8'd71,  1'b1, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd126, 1'b1, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd255, 1'b0, 1'b0, ST_WAIT,    4'd0,       2'd0},
    '{8'd210, 1'b0, 1'b1, ST_INVALID, KEY_TEN,    2'd0}
  };

  // Sort a sample into its key; windows open at both ends, first match wins
  function automatic logic [KEY_W-1:0] ladder_key(input logic [SAMPLE_W-1:0] s);
    int v;
    v = s;
    if (v > 17  && v < 23)  return 4'd1;
    if (v > 35  && v < 41)  return 4'd2;
    if (v > 50  && v < 56)  return 4'd3;
    if (v > 103 && v < 109) return 4'd4;
    if (v > 86  && v < 92)  return 4'd5;
    if (v > 68  && v < 74)  return 4'd6;
    if (v > 123 && v < 129) return 4'd7;
    if (v > 145 && v < 151) return 4'd8;
    if (v > 166 && v < 172) return 4'd9;
    if (v > 230 && v < 236) return 4'd0;
    if (v > 207 && v < 213) return KEY_TEN;
    if (v > 186 && v < 192) return KEY_CANCEL;
    if (v > 248 && v < 252) return KEY_UNUSED;
    if (v > 251)            return KEY_IDLE;
    return KEY_ERROR;
  endfunction

  // Pick a random sample that decodes to key k
  function automatic logic [SAMPLE_W-1:0] key_sample(input int k);
    int                  lo;
    int                  span;
    logic [SAMPLE_W-1:0] s;
    span = 5;
    case (k)
      0:          lo = 230;
      1:          lo = 17;
      2:          lo = 35;
      3:          lo = 50;
      4:          lo = 103;
      5:          lo = 86;
      6:          lo = 68;
      7:          lo = 123;
      8:          lo = 145;
      9:          lo = 166;
      KEY_TEN:    lo = 207;
      KEY_CANCEL: lo = 186;
      KEY_UNUSED: begin
        lo   = 248;
        span = 3;
      end
      KEY_IDLE: begin
        lo   = 251;
        span = 4;
      end
      default: begin
        do s = SAMPLE_W'($urandom_range(255)); while (ladder_key(s) != KEY_ERROR);
        return s;
      end
    endcase
    return SAMPLE_W'(lo + $urandom_range(span, 1));
  endfunction

  // Take the current key as the next digit; close the entry when full
  function automatic void take_digit(inout entry_result_t r);
    r.idx = pred_taken[INDEX_W-1:0];
    pred_taken++;
    if (pred_taken >= ENTRY_DIGITS) begin
      pred_phase = PH_NONE;
      r.status   = ST_DONE;
    end else begin
      pred_phase = PH_RELEASE;
      r.status   = ST_DIGIT;
    end
  endfunction

  // Advance the entry sequence by one sample and form its result
  function automatic entry_result_t entry_step(input logic [SAMPLE_W-1:0] s,
                                               input logic start);
    entry_result_t r;
    r.key    = ladder_key(s);
    r.status = ST_WAIT;
    r.idx    = '0;
    if (start) begin
      pred_taken = 0;
      pred_phase = PH_NONE;
      if (r.key == KEY_IDLE || r.key == KEY_ERROR) r.status = ST_NOKEY;
      else if (r.key == KEY_TEN) r.status = ST_INVALID;
      else take_digit(r);
    end else begin
      case (pred_phase)
        PH_RELEASE: begin
          if (r.key == KEY_IDLE) pred_phase = PH_PRESS;
        end
        PH_PRESS: begin
          if (r.key == KEY_IDLE || r.key == KEY_ERROR) begin
            // hold: still waiting for a press
          end else if (r.key == KEY_CANCEL) begin
            r.status   = ST_CANCEL;
            pred_phase = PH_NONE;
          end else if (r.key == KEY_UNUSED || r.key == KEY_TEN) begin
            r.status   = ST_INVALID;
            pred_phase = PH_NONE;
          end else begin
            take_digit(r);
          end
        end
        default: pred_phase = PH_NONE;
      endcase
    end
    return r;
  endfunction

  // Present one sample and hold it until the transfer happens
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid     <= 1'b1;
    smp_ch.sample    <= s;
    smp_ch.start_req <= start;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
  endtask

  // Random entries: mostly clean press/release sequences, some bounce and noise
  task automatic random_entries(input int count);
    int                  n;
    int                  r;
    logic [SAMPLE_W-1:0] s;
    logic                start;
    for (n = 0; n < count; n++) begin
      r     = $urandom_range(99);
      start = 1'b0;
      if (r < 4) begin
        s     = SAMPLE_W'($urandom_range(255));
        start = 1'($urandom_range(1));
      end else if (pred_phase == PH_NONE) begin
        start = (r >= 8);
        s = ($urandom_range(99) < 85) ? key_sample($urandom_range(9))
                                      : key_sample($urandom_range(14));
      end else if (r < 6) begin
        // restart in the middle of an entry
        start = 1'b1;
        s     = key_sample($urandom_range(9));
      end else if (pred_phase == PH_RELEASE) begin
        s = ($urandom_range(99) < 80) ? key_sample(KEY_IDLE)
                                      : key_sample($urandom_range(14));
      end else begin
        r = $urandom_range(99);
        if (r < 70)      s = key_sample($urandom_range(9));
        else if (r < 82) s = key_sample($urandom_range(KEY_ERROR, KEY_IDLE));
        else             s = key_sample($urandom_range(KEY_UNUSED, KEY_TEN));
      end
      send_sample(s, start);
      pending_results.push_back(entry_step(s, start));
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check each result transfer and drive the receiver's ready
  always @(posedge clk) begin : result_check
    entry_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing pending: status %0d key %0d index %0d",
                   $time, res_ch.status, res_ch.key, res_ch.digit_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status !== want.status || res_ch.key !== want.key ||
            res_ch.digit_index !== want.idx) begin
          if (mismatches < 10)
            $display("%0t: expected status %0d key %0d index %0d, got %0d %0d %0d",
                     $time, want.status, want.key, want.idx,
                     res_ch.status, res_ch.key, res_ch.digit_index);
          mismatches++;
        end
      end
    end
    res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Stimulus and end of run
  initial begin : stimulus
    int            i;
    entry_result_t got;
    rst              <= 1'b1;
    smp_ch.valid     <= 1'b0;
    smp_ch.sample    <= '0;
    smp_ch.start_req <= 1'b0;
    src_idle_pct   = 33;
    sink_stall_pct = 60;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; typed rows carry their own expectation
    for (i = 0; i < DIR_ROWS; i++) begin
      send_sample(directed_rows[i].sample, directed_rows[i].start);
      got = entry_step(directed_rows[i].sample, directed_rows[i].start);
      if (directed_rows[i].typed)
        pending_results.push_back(entry_result_t'{directed_rows[i].status,
                                                  directed_rows[i].key,
                                                  directed_rows[i].idx});
      else
        pending_results.push_back(got);
    end

    random_entries(RAND_ITEMS);
    src_idle_pct   = 60;
    sink_stall_pct = 33;
    random_entries(RAND_ITEMS);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_entries(RAND_ITEMS);
    smp_ch.valid <= 1'b0;

    // Drain, then wait for stray results before the verdict
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  initial begin
    #2_400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
